>>> hdl/isl_pkg.sv
// ----------------------------------------------------------------------------
// isl_pkg: shared definitions for the indexed sequence list
// Sizes, status and operation codes, the cell command bundle and the
// helpers that move values between the port width and the element width.
// ----------------------------------------------------------------------------
package isl_pkg;

  localparam int CAPACITY   = 16;
  localparam int ELEM_WIDTH = 32;

  // fixed field widths of the channels
  localparam int OP_W    = 1;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int LEN_W   = 5;

  // element count needs to hold CAPACITY itself
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int IDX_W   = $clog2(CAPACITY);
  // compare width wide enough for count + 1 and for any position
  localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } isl_op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_RANGE     = 2'd2,
    ST_OVERFLOW  = 2'd3
  } isl_status_t;

  typedef logic [ELEM_WIDTH-1:0] isl_elem_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] idx;
    isl_elem_t        val;
  } isl_cmd_t;

  // keep a port value to the element width
  function automatic isl_elem_t to_elem(input logic [VAL_W-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[ELEM_WIDTH-1:0];
  endfunction

  // bring an element back to the port width
  function automatic logic [VAL_W-1:0] to_field(input isl_elem_t e);
    logic [63:0] w;
    w = 64'(e);
    return w[VAL_W-1:0];
  endfunction

endpackage

>>> hdl/isl_if.sv
// ----------------------------------------------------------------------------
// isl_if: request and result channels of the indexed sequence list
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface isl_in_if;
  logic                       valid;
  logic                       ready;
  logic [isl_pkg::OP_W-1:0]   operation;
  logic [isl_pkg::POS_W-1:0]  position;
  logic [isl_pkg::VAL_W-1:0]  value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink   (input valid, input operation, input position, input value,
                  output ready);
endinterface

interface isl_out_if;
  logic                       valid;
  logic                       ready;
  logic [isl_pkg::VAL_W-1:0]  removed_value;
  logic [isl_pkg::STAT_W-1:0] status;
  logic [isl_pkg::LEN_W-1:0]  length;
  logic                       is_empty;

  modport source (output valid, output removed_value, output status,
                  output length, output is_empty, input ready);
  modport sink   (input valid, input removed_value, input status,
                  input length, input is_empty, output ready);
endinterface

>>> hdl/isl_cell.sv
// ----------------------------------------------------------------------------
// isl_cell: one storage slot of the list row
// Holds one element; on insert it takes the new value or its front
// neighbor, on delete it takes its rear neighbor.
// ----------------------------------------------------------------------------
module isl_cell (
  input  logic                  clk,
  input  isl_pkg::isl_cmd_t     cmd,
  input  logic [isl_pkg::IDX_W-1:0] cell_idx,
  input  isl_pkg::isl_elem_t    prev_val,
  input  isl_pkg::isl_elem_t    next_val,
  output isl_pkg::isl_elem_t    elem_q
);

  isl_pkg::isl_elem_t elem_r;
  isl_pkg::isl_elem_t elem_nxt;

  // pick the new content of this slot
  always_comb begin
    elem_nxt = elem_r;
    if (cmd.ins) begin
      if (cell_idx == cmd.idx) begin
        elem_nxt = cmd.val;
      end else if (cell_idx > cmd.idx) begin
        elem_nxt = prev_val;
      end
    end else if (cmd.del) begin
      if (cell_idx >= cmd.idx) begin
        elem_nxt = next_val;
      end
    end
  end

  // hold payload, no reset needed
  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
  end

  assign elem_q = elem_r;

endmodule

>>> hdl/indexed_sequence_list.sv
// Result: registered on the request's transfer and shown in the next cycle.
// Throughput: one request per cycle; the whole cell row shifts in that cycle.
// A waiting result holds the next request unless the sink takes it that cycle.
// Reset: synchronous, active low; clears the element count and the result
// valid. Element slots are not cleared and there is no clearing pass.
// ----------------------------------------------------------------------------
// indexed_sequence_list: bounded ordered list with insert/delete at position
// Decodes each request against the count, drives a row of shifting cells
// and registers one result per request.
// ----------------------------------------------------------------------------
module indexed_sequence_list (
  input  logic      clk,
  input  logic      rst_n,
  isl_in_if.sink    in_ch,
  isl_out_if.source out_ch
);

  localparam int N = isl_pkg::CAPACITY;

  logic [isl_pkg::CNT_W-1:0] count_r;
  logic [isl_pkg::CNT_W-1:0] count_nxt;

  logic                        out_valid_r;
  logic [isl_pkg::VAL_W-1:0]   removed_r;
  isl_pkg::isl_status_t        status_r;
  logic [isl_pkg::LEN_W-1:0]   length_r;
  logic                        empty_r;

  logic                        xfer;
  logic [isl_pkg::CMP_W-1:0]   pos_e;
  logic [isl_pkg::CMP_W-1:0]   cnt_e;
  logic [isl_pkg::CMP_W-1:0]   pidx_e;
  isl_pkg::isl_status_t        status_c;
  logic                        ins_ok;
  logic                        del_ok;
  isl_pkg::isl_cmd_t           cmd;
  isl_pkg::isl_elem_t          elem [N];
  isl_pkg::isl_elem_t          removed_c;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign xfer        = in_ch.valid && in_ch.ready;

  // check the request against the current count
  always_comb begin
    pos_e    = isl_pkg::CMP_W'(in_ch.position);
    cnt_e    = isl_pkg::CMP_W'(count_r);
    pidx_e   = pos_e - isl_pkg::CMP_W'(1);
    status_c = isl_pkg::ST_OK;
    unique case (isl_pkg::isl_op_t'(in_ch.operation))
      isl_pkg::OP_INSERT: begin
        if (pos_e == '0 || pos_e > cnt_e + isl_pkg::CMP_W'(1)) begin
          status_c = isl_pkg::ST_RANGE;
        end else if (cnt_e == isl_pkg::CMP_W'(N)) begin
          status_c = isl_pkg::ST_OVERFLOW;
        end
      end
      isl_pkg::OP_DELETE: begin
        if (cnt_e == '0) begin
          status_c = isl_pkg::ST_UNDERFLOW;
        end else if (pos_e == '0 || pos_e > cnt_e) begin
          status_c = isl_pkg::ST_RANGE;
        end
      end
      default: status_c = isl_pkg::ST_RANGE;
    endcase
  end

  assign ins_ok = xfer && (status_c == isl_pkg::ST_OK) &&
                  (isl_pkg::isl_op_t'(in_ch.operation) == isl_pkg::OP_INSERT);
  assign del_ok = xfer && (status_c == isl_pkg::ST_OK) &&
                  (isl_pkg::isl_op_t'(in_ch.operation) == isl_pkg::OP_DELETE);

  // broadcast the shift command to the row
  always_comb begin
    cmd.ins = ins_ok;
    cmd.del = del_ok;
    cmd.idx = pidx_e[isl_pkg::IDX_W-1:0];
    cmd.val = isl_pkg::to_elem(in_ch.value);
  end

  // row of cells, each wired to its neighbors
  for (genvar i = 0; i < N; i++) begin : g_cell
    isl_pkg::isl_elem_t prev_v;
    isl_pkg::isl_elem_t next_v;
    if (i == 0) begin : g_head
      assign prev_v = cmd.val;
    end else begin : g_body
      assign prev_v = elem[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign next_v = elem[i];
    end else begin : g_inner
      assign next_v = elem[i+1];
    end
    isl_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .cell_idx (isl_pkg::IDX_W'(i)),
      .prev_val (prev_v),
      .next_val (next_v),
      .elem_q   (elem[i])
    );
  end

  // read the slot being removed
  assign removed_c = elem[cmd.idx];

  // advance the count
  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + isl_pkg::CNT_W'(1);
    end else if (del_ok) begin
      count_nxt = count_r - isl_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // capture the result payload on each transfer
  always_ff @(posedge clk) begin
    if (xfer) begin
      removed_r <= del_ok ? isl_pkg::to_field(removed_c) : '0;
      status_r  <= status_c;
      length_r  <= isl_pkg::LEN_W'(count_nxt);
      empty_r   <= (count_nxt == '0);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.removed_value = removed_r;
  assign out_ch.status        = status_r;
  assign out_ch.length        = length_r;
  assign out_ch.is_empty      = empty_r;

  // count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= isl_pkg::CNT_W'(N))
    else $error("list count above capacity");

  // a good insert grows the list by one
  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    ins_ok |=> count_r == $past(count_r) + isl_pkg::CNT_W'(1))
    else $error("insert did not grow the list");

  // a refused request leaves the count alone
  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && status_c != isl_pkg::ST_OK) |=> $stable(count_r))
    else $error("rejected request changed the count");

  // reported length follows the count after a transfer
  a_len_match: assert property (@(posedge clk) disable iff (!rst_n)
    xfer |=> (length_r == isl_pkg::LEN_W'(count_r)) && (empty_r == (count_r == '0)))
    else $error("result length differs from count");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the indexed sequence list
// Directed rows hit the empty, full and out-of-range corners. Random requests
// then steer the list between empty and full. A shadow list predicts the
// untyped results, with random sender gaps and receiver stalls throughout.
// ----------------------------------------------------------------------------
module tb_top;
  import isl_pkg::*;

  localparam int RANDOM_ITEMS   = 1000;
  localparam int DIRECTED_ROWS  = 26;
  localparam int IDLE_LIMIT     = 2000;
  localparam int HOLD_CYCLES    = 120;
  localparam int PRESSURE_AFTER = 300;
  localparam int DRAIN_CYCLES   = 4;

  typedef struct packed {
    logic [VAL_W-1:0] removed_value;
    isl_status_t      status;
    logic [LEN_W-1:0] length;
    logic             is_empty;
  } list_result_t;

  typedef struct {
    isl_op_t          op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int               rep;
    bit               typed;
    list_result_t     want;
  } stim_row_t;

  typedef enum int {
    SINK_ALWAYS,
    SINK_COIN,
    SINK_THREE_OF_FOUR,
    SINK_MOSTLY
  } sink_mode_t;

  localparam list_result_t NO_CHECK = '0;

  logic clk;
  logic rst_n;

  isl_in_if  in_if ();
  isl_out_if out_if ();

  indexed_sequence_list dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // shadow copy of the list
  isl_elem_t   shadow_cells [CAPACITY];
  int unsigned shadow_count;

  list_result_t expected_results [$];
  int unsigned  mismatch_count;
  int unsigned  items_sent;
  int unsigned  burst_left;
  int unsigned  idle_cycles;
  bit           fill_bias;
  bit           pressure_done;

  // insert/delete corners; untyped rows take their result from the shadow list
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_DELETE, 5'd1,  32'h0,         1,  1'b1, '{32'h0, ST_UNDERFLOW, 5'd0, 1'b1}},
    '{OP_DELETE, 5'd0,  32'h0,         1,  1'b1, '{32'h0, ST_UNDERFLOW, 5'd0, 1'b1}},
    '{OP_DELETE, 5'd31, 32'h0,         1,  1'b1, '{32'h0, ST_UNDERFLOW, 5'd0, 1'b1}},
    '{OP_INSERT, 5'd0,  32'hDEADBEEF,  1,  1'b1, '{32'h0, ST_RANGE,     5'd0, 1'b1}},
    '{OP_INSERT, 5'd2,  32'hDEADBEEF,  1,  1'b1, '{32'h0, ST_RANGE,     5'd0, 1'b1}},
    '{OP_INSERT, 5'd31, 32'hDEADBEEF,  1,  1'b1, '{32'h0, ST_RANGE,     5'd0, 1'b1}},
    '{OP_INSERT, 5'd1,  32'h00000000,  1,  1'b1, '{32'h0, ST_OK,        5'd1, 1'b0}},
    '{OP_INSERT, 5'd2,  32'hFFFFFFFF,  1,  1'b1, '{32'h0, ST_OK,        5'd2, 1'b0}},
    '{OP_INSERT, 5'd1,  32'hA5A5A5A5,  1,  1'b1, '{32'h0, ST_OK,        5'd3, 1'b0}},
    '{OP_INSERT, 5'd4,  32'h5A5A5A5A,  1,  1'b1, '{32'h0, ST_OK,        5'd4, 1'b0}},
    '{OP_INSERT, 5'd3,  32'h12345678,  1,  1'b0, NO_CHECK},
    '{OP_DELETE, 5'd0,  32'h0,         1,  1'b1, '{32'h0, ST_RANGE,     5'd5, 1'b0}},
    '{OP_DELETE, 5'd6,  32'h0,         1,  1'b1, '{32'h0, ST_RANGE,     5'd5, 1'b0}},
    '{OP_DELETE, 5'd1,  32'hFFFFFFFF,  1,  1'b1, '{32'hA5A5A5A5, ST_OK, 5'd4, 1'b0}},
    '{OP_DELETE, 5'd4,  32'h0,         1,  1'b0, NO_CHECK},
    '{OP_DELETE, 5'd2,  32'h0,         1,  1'b0, NO_CHECK},
    '{OP_INSERT, 5'd1,  32'hC3C3C3C3,  14, 1'b0, NO_CHECK},
    '{OP_INSERT, 5'd17, 32'h11111111,  1,  1'b1, '{32'h0, ST_OVERFLOW,  5'd16, 1'b0}},
    '{OP_INSERT, 5'd1,  32'h22222222,  1,  1'b1, '{32'h0, ST_OVERFLOW,  5'd16, 1'b0}},
    '{OP_INSERT, 5'd18, 32'h33333333,  1,  1'b1, '{32'h0, ST_RANGE,     5'd16, 1'b0}},
    '{OP_INSERT, 5'd0,  32'h44444444,  1,  1'b1, '{32'h0, ST_RANGE,     5'd16, 1'b0}},
    '{OP_DELETE, 5'd16, 32'h0,         1,  1'b0, NO_CHECK},
    '{OP_DELETE, 5'd16, 32'h0,         1,  1'b1, '{32'h0, ST_RANGE,     5'd15, 1'b0}},
    '{OP_DELETE, 5'd1,  32'h0,         15, 1'b0, NO_CHECK},
    '{OP_DELETE, 5'd1,  32'h0,         1,  1'b1, '{32'h0, ST_UNDERFLOW, 5'd0, 1'b1}},
    '{OP_INSERT, 5'd1,  32'h0F0F0F0F,  1,  1'b1, '{32'h0, ST_OK,        5'd1, 1'b0}}
  };

  // clock and the single reset pulse
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // apply one request to the shadow list and return its result
  function automatic list_result_t apply_request(input isl_op_t op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [VAL_W-1:0] val);
    list_result_t res;
    int unsigned  p;
    res = '0;
    res.status = ST_OK;
    p = int'(pos);
    if (op == OP_INSERT) begin
      if (p < 1 || p > shadow_count + 1) begin
        res.status = ST_RANGE;
      end else if (shadow_count >= CAPACITY) begin
        res.status = ST_OVERFLOW;
      end else begin
        // open a gap by moving the tail back one place
        for (int i = shadow_count; i > p - 1; i--) shadow_cells[i] = shadow_cells[i-1];
        shadow_cells[p-1] = isl_elem_t'(val);
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = ST_UNDERFLOW;
      end else if (p < 1 || p > shadow_count) begin
        res.status = ST_RANGE;
      end else begin
        res.removed_value = VAL_W'(shadow_cells[p-1]);
        for (int i = p - 1; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i+1];
        shadow_count--;
      end
    end
    res.length   = LEN_W'(shadow_count);
    res.is_empty = (shadow_count == 0);
    return res;
  endfunction

  // drop valid for a random gap once the current burst runs out
  task automatic sender_pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
    end
  endtask

  // offer one request, hold it until the transfer, then record the result
  task automatic send_request(input isl_op_t op, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val, input bit typed,
                              input list_result_t typed_want);
    list_result_t predicted;
    sender_pace();
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.position  <= pos;
    in_if.value     <= val;
    do @(posedge clk); while (!in_if.ready);
    predicted = apply_request(op, pos, val);
    expected_results.push_back(typed ? typed_want : predicted);
    items_sent++;
  endtask

  // random request steered toward filling or draining the list
  task automatic pick_request(output isl_op_t op, output logic [POS_W-1:0] pos,
                              output logic [VAL_W-1:0] val);
    int unsigned kind;
    if (shadow_count == CAPACITY || shadow_count == 0) begin
      if ($urandom_range(3) == 0) fill_bias = (shadow_count == 0);
    end else if ($urandom_range(49) == 0) begin
      fill_bias = !fill_bias;
    end
    if (($urandom_range(99) < 70) == fill_bias) op = OP_INSERT;
    else op = OP_DELETE;
    kind = $urandom_range(99);
    if (kind < 85) begin
      if (op == OP_INSERT) pos = POS_W'($urandom_range(1, shadow_count + 1));
      else pos = POS_W'($urandom_range(1, shadow_count));
    end else if (kind < 93) begin
      // one past the legal edge, or zero
      if ($urandom_range(1) == 0) pos = '0;
      else pos = POS_W'(shadow_count + ((op == OP_INSERT) ? 2 : 1));
    end else begin
      pos = POS_W'($urandom_range(31));
    end
    case ($urandom_range(9))
      0:       val = '0;
      1:       val = '1;
      default: val = $urandom;
    endcase
  endtask

  // stimulus and end of run
  initial begin : stimulus
    isl_op_t          op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    in_if.valid     <= 1'b0;
    in_if.operation <= OP_INSERT;
    in_if.position  <= '0;
    in_if.value     <= '0;
    shadow_count   = 0;
    mismatch_count = 0;
    items_sent     = 0;
    burst_left     = 0;
    fill_bias      = 1'b1;
    do @(posedge clk); while (!rst_n);

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].rep; k++) begin
        send_request(directed_rows[r].op, directed_rows[r].pos, directed_rows[r].val + k,
                     directed_rows[r].typed, directed_rows[r].want);
      end
    end

    repeat (RANDOM_ITEMS) begin
      pick_request(op, pos, val);
      send_request(op, pos, val, 1'b0, NO_CHECK);
    end
    in_if.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // receiver stalls on a changing pattern, with one long hold-off
  initial begin : result_sink
    int unsigned sink_cycle;
    sink_mode_t  mode;
    out_if.ready <= 1'b0;
    sink_cycle = 0;
    mode = SINK_ALWAYS;
    pressure_done = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!pressure_done && items_sent >= PRESSURE_AFTER) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        pressure_done = 1'b1;
      end else begin
        if (sink_cycle % 64 == 0) mode = sink_mode_t'($urandom_range(3));
        case (mode)
          SINK_ALWAYS:        out_if.ready <= 1'b1;
          SINK_COIN:          out_if.ready <= 1'($urandom_range(1));
          SINK_THREE_OF_FOUR: out_if.ready <= (sink_cycle % 4 != 3);
          default:            out_if.ready <= ($urandom_range(99) < 85);
        endcase
      end
      sink_cycle++;
      @(posedge clk);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // compare each result transfer with the oldest expectation; watchdog
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h/%0d/%0d/%b", $time,
                   out_if.removed_value, out_if.status, out_if.length, out_if.is_empty);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("removed_value", want.removed_value, out_if.removed_value);
          check_field("status", 32'(want.status), 32'(out_if.status));
          check_field("length", 32'(want.length), 32'(out_if.length));
          check_field("is_empty", 32'(want.is_empty), 32'(out_if.is_empty));
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

endmodule
